// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset
`define TVC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included
`define TVC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/tvc_pkg.sv
package tvc_pkg;

    // pipeline lengths of the iterative units
    localparam int CORDIC_STEPS = 24;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 31;

    // 1.0 in Q.29 and the small-angle threshold (about 1e-6)
    localparam logic [63:0] ONE_Q29   = 64'h0000_0000_2000_0000;
    localparam logic [31:0] TINY_NORM = 32'd537;

    // register reset values
    localparam logic [15:0] PROP_GAIN_RST    = 16'd256;
    localparam logic [15:0] DERIV_GAIN_RST   = 16'd26;
    localparam logic [14:0] GIMBAL_LIMIT_RST = 15'd5719;

    typedef enum logic [1:0] {
        CFG_PROP_GAIN    = 2'd0,
        CFG_DERIV_GAIN   = 2'd1,
        CFG_GIMBAL_LIMIT = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic        [15:0] tick_dt;
    } t_tick;

    typedef struct packed {
        logic signed [15:0] cmd_yaw;
        logic signed [15:0] cmd_pitch;
        logic signed [15:0] err_yaw;
        logic signed [15:0] err_pitch;
        logic               saturated;
    } t_cmd;

    typedef struct packed {
        logic [15:0] prop_gain;
        logic [15:0] deriv_gain;
        logic [14:0] gimbal_limit;
    } t_gains;

    // atan(2^-i) in Q.30
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:    v = 30'h3243F6A8;
            5'd1:    v = 30'h1DAC6705;
            5'd2:    v = 30'h0FADBAFC;
            5'd3:    v = 30'h07F56EA6;
            5'd4:    v = 30'h03FEAB76;
            5'd5:    v = 30'h01FFD55B;
            5'd6:    v = 30'h00FFFAAA;
            5'd7:    v = 30'h007FFF55;
            5'd8:    v = 30'h003FFFEA;
            5'd9:    v = 30'h001FFFFD;
            5'd10:   v = 30'h000FFFFF;
            5'd11:   v = 30'h0007FFFF;
            5'd12:   v = 30'h0003FFFF;
            5'd13:   v = 30'h0001FFFF;
            5'd14:   v = 30'h0000FFFF;
            5'd15:   v = 30'h00007FFF;
            5'd16:   v = 30'h00003FFF;
            5'd17:   v = 30'h00001FFF;
            5'd18:   v = 30'h00000FFF;
            5'd19:   v = 30'h000007FF;
            5'd20:   v = 30'h000003FF;
            5'd21:   v = 30'h000001FF;
            5'd22:   v = 30'h000000FF;
            5'd23:   v = 30'h0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: sv/tvc_if.sv
// tick stream into the controller
interface tvc_tick_if;
    logic          valid;
    logic          ready;
    tvc_pkg::t_tick payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// command stream out of the controller
interface tvc_cmd_if;
    logic          valid;
    logic          ready;
    tvc_pkg::t_cmd payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// register write channel
interface tvc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/tvc_pd_attitude_control.sv
// Thrust-vector PD attitude controller.
// i_tick carries one tick per beat: attitude quaternion (Q1.15), body rates
// about X and Y (Q6.10) and the time step. A tick with a zero time step is
// accepted and dropped; every other tick gives exactly one beat on o_cmd with
// the gimbal commands, the attitude errors and the saturation flag, in order.
// i_cfg writes prop_gain (0), deriv_gain (1) and gimbal_limit (2); other
// indexes are ignored. It is always ready; write it only while idle.
// Throughput: one tick per cycle while o_cmd does not stall. The datapath
// is fully pipelined: two 32-stage square roots, a 24-stage CORDIC for
// the angle and a 31-stage divider for the error axis, plus the product
// and rounding stages. A front stage and a small tick queue sit ahead of
// that pipeline.
// Reset clears all valids and loads the register defaults (256, 26, 5719).
// When o_cmd stalls, the result waits in the output register and the
// pipeline freezes; the queue then fills and i_tick.ready drops.
module tvc_pd_attitude_control #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tvc_tick_if.sink   i_tick,
    tvc_cmd_if.source  o_cmd,
    tvc_cfg_if.sink    i_cfg
);

    tvc_pkg::t_gains r_gains;
    logic            w_push;
    tvc_pkg::t_tick  w_push_item;
    logic            w_full;
    logic            w_q_vld;
    tvc_pkg::t_tick  w_q_item;
    logic            w_pop;

    // register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.prop_gain    <= tvc_pkg::PROP_GAIN_RST;
            r_gains.deriv_gain   <= tvc_pkg::DERIV_GAIN_RST;
            r_gains.gimbal_limit <= tvc_pkg::GIMBAL_LIMIT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                tvc_pkg::CFG_PROP_GAIN:    r_gains.prop_gain    <= i_cfg.data;
                tvc_pkg::CFG_DERIV_GAIN:   r_gains.deriv_gain   <= i_cfg.data;
                tvc_pkg::CFG_GIMBAL_LIMIT: r_gains.gimbal_limit <= i_cfg.data[14:0];
                default: ;
            endcase
        end
    end

    tvc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (i_tick),
        .i_q_full (w_full),
        .o_q_push (w_push),
        .o_q_item (w_push_item)
    );

    tvc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_vld   (w_q_vld),
        .o_item  (w_q_item)
    );

    tvc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_gains  (r_gains),
        .i_q_vld  (w_q_vld),
        .i_q_item (w_q_item),
        .o_q_pop  (w_pop),
        .o_cmd    (o_cmd)
    );

endmodule

// File: sv/tvc_front.sv
module tvc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tvc_tick_if.sink       i_tick,
    input  logic           i_q_full,
    output logic           o_q_push,
    output tvc_pkg::t_tick o_q_item
);

    logic           r_vld;
    tvc_pkg::t_tick r_item;
    logic           w_take;
    logic           w_keep;

    // a held beat moves to the queue when there is room
    assign o_q_push     = r_vld && !i_q_full;
    assign o_q_item     = r_item;
    assign i_tick.ready = !r_vld || !i_q_full;
    assign w_take       = i_tick.valid && i_tick.ready;
    // ticks with zero time step give no result and are dropped here
    assign w_keep       = (i_tick.payload.tick_dt != 16'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_tick.ready) begin
            r_vld <= w_take && w_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= i_tick.payload;
        end
    end

endmodule

// File: sv/tvc_queue.sv
module tvc_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tvc_pkg::t_tick i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_vld,
    output tvc_pkg::t_tick o_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tvc_pkg::t_tick r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic [AW-1:0]  n_wr;
    logic [AW-1:0]  n_rd;
    logic           w_push;
    logic           w_pop;

    assign o_full = (r_cnt == CW'(DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_item = r_mem[r_rd];
    assign w_push = i_push && !o_full;
    assign w_pop  = i_pop && o_vld;

    // pointer wrap
    assign n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
    assign n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= n_wr;
            if (w_pop)  r_rd <= n_rd;
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// File: sv/tvc_back.sv
module tvc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tvc_pkg::t_gains i_gains,
    input  logic            i_q_vld,
    input  tvc_pkg::t_tick  i_q_item,
    output logic            o_q_pop,
    tvc_cmd_if.source       o_cmd
);

    typedef struct packed {
        logic signed [15:0] qw, qx, qy, qz, rx, ry;
        logic signed [31:0] m_yy, m_zz, m_xx, m_xy, m_wz, m_xz, m_wy, m_yz, m_wx;
        logic signed [32:0] r00, r01, r10, r11, r02, r12;
        logic        [63:0] sq_a, sq_b;
        logic        [63:0] rem, root;
        logic        [31:0] norm;
        logic        [29:0] sv;
        logic signed [39:0] cx, cy;
        logic signed [33:0] cz;
        logic        [31:0] ang;
        logic        [63:0] drx, dry;
        logic        [30:0] qtx, qty;
        logic signed [31:0] ax, ay;
        logic signed [64:0] p0, p1, p2, p3;
        logic signed [22:0] bx, by;
        logic signed [55:0] epx, epy;
        logic signed [15:0] ex, ey;
        logic signed [32:0] kdx, kdy, kpx, kpy;
    } t_ctx;

    // stage map
    localparam int ST_PROD = 1;
    localparam int ST_RMAT = 2;
    localparam int ST_SQ   = 3;
    localparam int ST_N2   = 4;
    localparam int ST_SQ1  = 5;
    localparam int ST_SS   = ST_SQ1 + tvc_pkg::SQRT_STEPS;
    localparam int ST_C2   = ST_SS + 1;
    localparam int ST_SQ2  = ST_C2 + 1;
    localparam int ST_CI   = ST_SQ2 + tvc_pkg::SQRT_STEPS;
    localparam int ST_COR  = ST_CI + 1;
    localparam int ST_ANG  = ST_COR + tvc_pkg::CORDIC_STEPS;
    localparam int ST_DIV  = ST_ANG + 1;
    localparam int ST_AX   = ST_DIV + tvc_pkg::DIV_STEPS;
    localparam int ST_BP   = ST_AX + 1;
    localparam int ST_BX   = ST_BP + 1;
    localparam int ST_EP   = ST_BX + 1;
    localparam int ST_EX   = ST_EP + 1;
    localparam int ST_UP   = ST_EX + 1;
    localparam int N_ST    = ST_UP;

    localparam logic signed [32:0] ONE_R   = 33'(tvc_pkg::ONE_Q29);
    localparam logic        [63:0] ONE_Q58 = 64'd1 << 58;

    // one bit of the integer square root
    function automatic t_ctx sqrt_step(input t_ctx c, input int k);
        logic [63:0] bit_v;
        logic [63:0] trial;
        t_ctx        o;
        o     = c;
        bit_v = 64'd1 << (62 - 2 * k);
        trial = c.root + bit_v;
        if (c.rem >= trial) begin
            o.rem  = c.rem - trial;
            o.root = (c.root >> 1) + bit_v;
        end else begin
            o.root = c.root >> 1;
        end
        return o;
    endfunction

    // one CORDIC vectoring rotation
    function automatic t_ctx cordic_step(input t_ctx c, input int i);
        logic signed [39:0] dx;
        logic signed [39:0] dy;
        logic signed [33:0] at;
        t_ctx               o;
        o  = c;
        dx = c.cy >>> i;
        dy = c.cx >>> i;
        at = $signed({4'b0, tvc_pkg::atan_q30(5'(i))});
        if (!c.cy[39]) begin
            o.cx = c.cx + dx;
            o.cy = c.cy - dy;
            o.cz = c.cz + at;
        end else begin
            o.cx = c.cx - dx;
            o.cy = c.cy + dy;
            o.cz = c.cz - at;
        end
        return o;
    endfunction

    // one quotient bit of both axis divides
    function automatic t_ctx div_step(input t_ctx c, input int i);
        logic [63:0] dv;
        t_ctx        o;
        o  = c;
        dv = 64'(c.norm) << i;
        if (c.drx >= dv) begin
            o.drx    = c.drx - dv;
            o.qtx[i] = 1'b1;
        end
        if (c.dry >= dv) begin
            o.dry    = c.dry - dv;
            o.qty[i] = 1'b1;
        end
        return o;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
        logic signed [15:0] o;
        if (v > 24'sd32767) begin
            o = 16'sh7FFF;
        end else if (v < -24'sd32768) begin
            o = 16'sh8000;
        end else begin
            o = v[15:0];
        end
        return o;
    endfunction

    t_ctx          w_head;
    t_ctx          r_st [1:N_ST];
    t_ctx          n_st [1:N_ST];
    logic [N_ST:1] r_vld;
    logic          w_en;
    logic          r_out_vld;
    tvc_pkg::t_cmd r_out;
    tvc_pkg::t_cmd w_out;

    // whole pipeline advances while the output slot is free or being taken
    assign w_en          = !r_out_vld || o_cmd.ready;
    assign o_q_pop       = w_en && i_q_vld;
    assign o_cmd.valid   = r_out_vld;
    assign o_cmd.payload = r_out;

    always_comb begin
        w_head    = '0;
        w_head.qw = i_q_item.quat_w;
        w_head.qx = i_q_item.quat_x;
        w_head.qy = i_q_item.quat_y;
        w_head.qz = i_q_item.quat_z;
        w_head.rx = i_q_item.rate_x;
        w_head.ry = i_q_item.rate_y;
    end

    // quaternion products
    always_comb begin
        n_st[ST_PROD]      = w_head;
        n_st[ST_PROD].m_yy = 32'(w_head.qy) * 32'(w_head.qy);
        n_st[ST_PROD].m_zz = 32'(w_head.qz) * 32'(w_head.qz);
        n_st[ST_PROD].m_xx = 32'(w_head.qx) * 32'(w_head.qx);
        n_st[ST_PROD].m_xy = 32'(w_head.qx) * 32'(w_head.qy);
        n_st[ST_PROD].m_wz = 32'(w_head.qw) * 32'(w_head.qz);
        n_st[ST_PROD].m_xz = 32'(w_head.qx) * 32'(w_head.qz);
        n_st[ST_PROD].m_wy = 32'(w_head.qw) * 32'(w_head.qy);
        n_st[ST_PROD].m_yz = 32'(w_head.qy) * 32'(w_head.qz);
        n_st[ST_PROD].m_wx = 32'(w_head.qw) * 32'(w_head.qx);
    end

    // rotation matrix entries, Q.29
    always_comb begin
        n_st[ST_RMAT]     = r_st[ST_PROD];
        n_st[ST_RMAT].r00 = ONE_R - (33'(r_st[ST_PROD].m_yy) + 33'(r_st[ST_PROD].m_zz));
        n_st[ST_RMAT].r11 = ONE_R - (33'(r_st[ST_PROD].m_xx) + 33'(r_st[ST_PROD].m_zz));
        n_st[ST_RMAT].r01 = 33'(r_st[ST_PROD].m_xy) - 33'(r_st[ST_PROD].m_wz);
        n_st[ST_RMAT].r10 = 33'(r_st[ST_PROD].m_xy) + 33'(r_st[ST_PROD].m_wz);
        n_st[ST_RMAT].r02 = 33'(r_st[ST_PROD].m_xz) + 33'(r_st[ST_PROD].m_wy);
        n_st[ST_RMAT].r12 = 33'(r_st[ST_PROD].m_yz) - 33'(r_st[ST_PROD].m_wx);
    end

    // squares of the world error components
    always_comb begin
        logic [32:0] a02;
        logic [32:0] a12;
        a02 = r_st[ST_RMAT].r02[32] ? 33'(-r_st[ST_RMAT].r02) : r_st[ST_RMAT].r02;
        a12 = r_st[ST_RMAT].r12[32] ? 33'(-r_st[ST_RMAT].r12) : r_st[ST_RMAT].r12;
        n_st[ST_SQ]      = r_st[ST_RMAT];
        n_st[ST_SQ].sq_a = 64'(a02[31:0]) * 64'(a02[31:0]);
        n_st[ST_SQ].sq_b = 64'(a12[31:0]) * 64'(a12[31:0]);
    end

    always_comb begin
        n_st[ST_N2]      = r_st[ST_SQ];
        n_st[ST_N2].rem  = r_st[ST_SQ].sq_a + r_st[ST_SQ].sq_b;
        n_st[ST_N2].root = '0;
    end

    // norm of the error vector
    for (genvar k = 0; k < tvc_pkg::SQRT_STEPS; k++) begin : g_sq1
        always_comb begin
            n_st[ST_SQ1 + k] = sqrt_step(r_st[ST_SQ1 + k - 1], k);
        end
    end

    // clamp the sine to 1
    always_comb begin
        n_st[ST_SS]      = r_st[ST_SS - 1];
        n_st[ST_SS].norm = r_st[ST_SS - 1].root[31:0];
        n_st[ST_SS].sv   = (r_st[ST_SS - 1].root > tvc_pkg::ONE_Q29) ?
                           30'(tvc_pkg::ONE_Q29) : r_st[ST_SS - 1].root[29:0];
    end

    always_comb begin
        n_st[ST_C2]      = r_st[ST_SS];
        n_st[ST_C2].rem  = ONE_Q58 - 64'(r_st[ST_SS].sv) * 64'(r_st[ST_SS].sv);
        n_st[ST_C2].root = '0;
    end

    // cosine of the error angle
    for (genvar k = 0; k < tvc_pkg::SQRT_STEPS; k++) begin : g_sq2
        always_comb begin
            n_st[ST_SQ2 + k] = sqrt_step(r_st[ST_SQ2 + k - 1], k);
        end
    end

    always_comb begin
        n_st[ST_CI]    = r_st[ST_CI - 1];
        n_st[ST_CI].cx = $signed({10'b0, r_st[ST_CI - 1].root[29:0]});
        n_st[ST_CI].cy = $signed({10'b0, r_st[ST_CI - 1].sv});
        n_st[ST_CI].cz = '0;
    end

    // angle = atan2(s, c)
    for (genvar k = 0; k < tvc_pkg::CORDIC_STEPS; k++) begin : g_cor
        always_comb begin
            n_st[ST_COR + k] = cordic_step(r_st[ST_COR + k - 1], k);
        end
    end

    // clamp the angle, load the axis dividends
    always_comb begin
        logic [32:0] a02;
        logic [32:0] a12;
        a02 = r_st[ST_ANG - 1].r02[32] ? 33'(-r_st[ST_ANG - 1].r02) : r_st[ST_ANG - 1].r02;
        a12 = r_st[ST_ANG - 1].r12[32] ? 33'(-r_st[ST_ANG - 1].r12) : r_st[ST_ANG - 1].r12;
        n_st[ST_ANG]     = r_st[ST_ANG - 1];
        n_st[ST_ANG].ang = r_st[ST_ANG - 1].cz[33] ? '0 : r_st[ST_ANG - 1].cz[31:0];
        n_st[ST_ANG].drx = 64'(a12[31:0]) << 30;
        n_st[ST_ANG].dry = 64'(a02[31:0]) << 30;
        n_st[ST_ANG].qtx = '0;
        n_st[ST_ANG].qty = '0;
    end

    // unit axis by restoring division, MSB first
    for (genvar k = 0; k < tvc_pkg::DIV_STEPS; k++) begin : g_div
        always_comb begin
            n_st[ST_DIV + k] = div_step(r_st[ST_DIV + k - 1], tvc_pkg::DIV_STEPS - 1 - k);
        end
    end

    // signs, small-angle axis
    always_comb begin
        logic               tiny;
        logic               r02_pos;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        tiny    = (r_st[ST_AX - 1].norm < tvc_pkg::TINY_NORM);
        r02_pos = !r_st[ST_AX - 1].r02[32] && (r_st[ST_AX - 1].r02 != '0);
        qx      = $signed({1'b0, r_st[ST_AX - 1].qtx});
        qy      = $signed({1'b0, r_st[ST_AX - 1].qty});
        n_st[ST_AX] = r_st[ST_AX - 1];
        if (tiny) begin
            n_st[ST_AX].ax = 32'sh4000_0000;
            n_st[ST_AX].ay = '0;
        end else begin
            n_st[ST_AX].ax = r_st[ST_AX - 1].r12[32] ? -qx : qx;
            n_st[ST_AX].ay = r02_pos ? -qy : qy;
        end
    end

    // axis back to the body frame: products
    always_comb begin
        n_st[ST_BP]    = r_st[ST_AX];
        n_st[ST_BP].p0 = 65'(r_st[ST_AX].r00) * 65'(r_st[ST_AX].ax);
        n_st[ST_BP].p1 = 65'(r_st[ST_AX].r10) * 65'(r_st[ST_AX].ay);
        n_st[ST_BP].p2 = 65'(r_st[ST_AX].r01) * 65'(r_st[ST_AX].ax);
        n_st[ST_BP].p3 = 65'(r_st[ST_AX].r11) * 65'(r_st[ST_AX].ay);
    end

    // sums, Q.59 to Q.16 rounded
    always_comb begin
        logic signed [65:0] sx;
        logic signed [65:0] sy;
        sx = 66'(r_st[ST_BP].p0) + 66'(r_st[ST_BP].p1) + (66'sd1 <<< 42);
        sy = 66'(r_st[ST_BP].p2) + 66'(r_st[ST_BP].p3) + (66'sd1 <<< 42);
        n_st[ST_BX]    = r_st[ST_BP];
        n_st[ST_BX].bx = 23'(sx >>> 43);
        n_st[ST_BX].by = 23'(sy >>> 43);
    end

    always_comb begin
        n_st[ST_EP]     = r_st[ST_BX];
        n_st[ST_EP].epx = 56'(r_st[ST_BX].bx) * $signed(56'(r_st[ST_BX].ang));
        n_st[ST_EP].epy = 56'(r_st[ST_BX].by) * $signed(56'(r_st[ST_BX].ang));
    end

    // errors, rounded and saturated to Q2.14
    always_comb begin
        logic signed [55:0] tx;
        logic signed [55:0] ty;
        tx = (r_st[ST_EP].epx + (56'sd1 <<< 31)) >>> 32;
        ty = (r_st[ST_EP].epy + (56'sd1 <<< 31)) >>> 32;
        n_st[ST_EX]    = r_st[ST_EP];
        n_st[ST_EX].ex = sat16(tx[23:0]);
        n_st[ST_EX].ey = sat16(ty[23:0]);
    end

    // gain products
    always_comb begin
        n_st[ST_UP]     = r_st[ST_EX];
        n_st[ST_UP].kdx = $signed({17'b0, i_gains.deriv_gain}) * 33'(r_st[ST_EX].rx);
        n_st[ST_UP].kdy = $signed({17'b0, i_gains.deriv_gain}) * 33'(r_st[ST_EX].ry);
        n_st[ST_UP].kpx = $signed({17'b0, i_gains.prop_gain}) * 33'(r_st[ST_EX].ex);
        n_st[ST_UP].kpy = $signed({17'b0, i_gains.prop_gain}) * 33'(r_st[ST_EX].ey);
    end

    // commands, Q.22 to Q1.15, clamped to the gimbal limit
    always_comb begin
        logic signed [37:0] vx;
        logic signed [37:0] vy;
        logic signed [37:0] ux;
        logic signed [37:0] uy;
        logic signed [37:0] lim;
        logic signed [37:0] cx;
        logic signed [37:0] cy;
        vx  = (38'(r_st[N_ST].kdx) <<< 4) - 38'(r_st[N_ST].kpx) + 38'sd64;
        vy  = (38'(r_st[N_ST].kdy) <<< 4) - 38'(r_st[N_ST].kpy) + 38'sd64;
        ux  = vx >>> 7;
        uy  = vy >>> 7;
        lim = $signed({23'b0, i_gains.gimbal_limit});
        cx  = (ux > lim) ? lim : ((ux < -lim) ? -lim : ux);
        cy  = (uy > lim) ? lim : ((uy < -lim) ? -lim : uy);
        w_out.cmd_yaw   = cx[15:0];
        w_out.cmd_pitch = cy[15:0];
        w_out.err_yaw   = r_st[N_ST].ex;
        w_out.err_pitch = r_st[N_ST].ey;
        w_out.saturated = (ux > lim) || (ux < -lim) || (uy > lim) || (uy < -lim);
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[N_ST-1:1], i_q_vld};
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 1; k <= N_ST; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_vld[N_ST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= w_out;
        end
    end

endmodule

// File: sv/tvc_chk.sv
`include "assert_macros.svh"

module tvc_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input tvc_pkg::t_cmd i_out_data,
    input logic          i_cfg_valid,
    input logic          i_cfg_ready,
    input logic [1:0]    i_cfg_index,
    input logic [15:0]   i_cfg_data
);

    logic [14:0]        r_lim;
    logic signed [15:0] w_lim;
    logic               w_in_lim;
    logic               w_at_lim;

    // mirror of the gimbal limit as written on the port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= tvc_pkg::GIMBAL_LIMIT_RST;
        end else if (i_cfg_valid && i_cfg_ready &&
                     (i_cfg_index == tvc_pkg::CFG_GIMBAL_LIMIT)) begin
            r_lim <= i_cfg_data[14:0];
        end
    end

    assign w_lim    = $signed({1'b0, r_lim});
    assign w_in_lim = (i_out_data.cmd_yaw <= w_lim) && (i_out_data.cmd_yaw >= -w_lim) &&
                      (i_out_data.cmd_pitch <= w_lim) && (i_out_data.cmd_pitch >= -w_lim);
    assign w_at_lim = (i_out_data.cmd_yaw == w_lim) || (i_out_data.cmd_yaw == -w_lim) ||
                      (i_out_data.cmd_pitch == w_lim) || (i_out_data.cmd_pitch == -w_lim);

    `TVC_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !i_out_valid, "result after reset")
    `TVC_ASSERT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "beat dropped")
    `TVC_ASSERT(a_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_out_data), "beat changed")
    `TVC_ASSERT(a_in_lim, i_clk, i_rst_n, i_out_valid |-> w_in_lim, "command beyond limit")
    `TVC_ASSERT(a_sat_lim, i_clk, i_rst_n, i_out_valid && i_out_data.saturated |-> w_at_lim, "flag without clamp")

endmodule

bind tvc_pd_attitude_control tvc_chk u_tvc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_cmd.valid),
    .i_out_ready (o_cmd.ready),
    .i_out_data  (o_cmd.payload),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready),
    .i_cfg_index (i_cfg.index),
    .i_cfg_data  (i_cfg.data)
);

// File: verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // index with no register behind it; writes to it must be ignored
    localparam logic [1:0] CFG_NO_REG  = 2'd3;
    localparam int         SETTLE_CYC  = 150;
    localparam int         STALL_LIMIT = 3000;
    localparam int         N_RANDOM    = 450;

    // expected-command store and fixed-point controller predictor
    class cmd_scoreboard;
        tvc_pkg::t_cmd cmd_q[$];
        logic [15:0]   kp;
        logic [15:0]   kd;
        logic [14:0]   lim_reg;
        int            errors;
        int            n_cmds;
        int            n_sat;
        int            n_tiny;
        longint        atan_q30[24];

        function new();
            atan_q30 = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                         64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                         64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                         64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
                         64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                         64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
            kp      = tvc_pkg::PROP_GAIN_RST;
            kd      = tvc_pkg::DERIV_GAIN_RST;
            lim_reg = tvc_pkg::GIMBAL_LIMIT_RST;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                tvc_pkg::CFG_PROP_GAIN:    kp = val;
                tvc_pkg::CFG_DERIV_GAIN:   kd = val;
                tvc_pkg::CFG_GIMBAL_LIMIT: lim_reg = val[14:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return cmd_q.size();
        endfunction

        // round half up after dropping k bits
        function longint round_shift(longint v, int k);
            longint h;
            h = longint'(1) << (k - 1);
            return (v + h) >>> k;
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function longint int_sqrt(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = longint'(1) << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return longint'(r);
        endfunction

        // num * 2^30 / den, truncated toward zero
        function longint axis_div(longint num, longint den);
            longint unsigned m;
            longint q;
            m = longint'(num < 0 ? -num : num) << 30;
            q = longint'(m / longint'(den));
            return num < 0 ? -q : q;
        endfunction

        // vectoring CORDIC: atan2(s, c), Q.29 in, Q.30 out
        function longint tilt_angle(longint s, longint c);
            longint x, y, z, dx, dy;
            x = c;
            y = s;
            z = 0;
            for (int i = 0; i < 24; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx; y -= dy; z += atan_q30[i];
                end else begin
                    x -= dx; y += dy; z -= atan_q30[i];
                end
            end
            return z < 0 ? 0 : z;
        endfunction

        function void note_tick(tvc_pkg::t_tick t);
            longint w, x, y, z, rx, ry, one;
            longint r00, r01, r10, r11, r02, r12, nrm, s, c, ang, ax, ay;
            longint bx, by, ex, ey, ux, uy, lim;
            longint unsigned n2;
            tvc_pkg::t_cmd e;
            if (t.tick_dt == 0) return;
            w  = longint'(t.quat_w);
            x  = longint'(t.quat_x);
            y  = longint'(t.quat_y);
            z  = longint'(t.quat_z);
            rx = longint'(t.rate_x);
            ry = longint'(t.rate_y);
            one = longint'(1) << 29;
            // body-to-world rotation in Q.29
            r00 = one - (y * y + z * z);
            r11 = one - (x * x + z * z);
            r01 = x * y - w * z;
            r10 = x * y + w * z;
            r02 = x * z + w * y;
            r12 = y * z - w * x;
            // tilt angle from norm of (body Z) x (world up)
            n2  = longint'(r02 * r02) + longint'(r12 * r12);
            nrm = int_sqrt(n2);
            s   = nrm > one ? one : nrm;
            c   = int_sqrt(longint'(one * one) - longint'(s * s));
            ang = tilt_angle(s, c);
            if (nrm < longint'(tvc_pkg::TINY_NORM)) begin
                ax = longint'(1) << 30;
                ay = 0;
                n_tiny++;
            end else begin
                ax = axis_div(r12, nrm);
                ay = axis_div(-r02, nrm);
            end
            // axis back into body frame via transpose
            bx = round_shift(r00 * ax + r10 * ay, 43);
            by = round_shift(r01 * ax + r11 * ay, 43);
            ex = clamp(round_shift(bx * ang, 32), -32768, 32767);
            ey = clamp(round_shift(by * ang, 32), -32768, 32767);
            // PD law, Q.22 then Q1.15
            ux = round_shift(longint'(kd) * rx * 16 - longint'(kp) * ex, 7);
            uy = round_shift(longint'(kd) * ry * 16 - longint'(kp) * ey, 7);
            lim = longint'(lim_reg);
            e.saturated = (ux > lim || ux < -lim || uy > lim || uy < -lim);
            e.cmd_yaw   = 16'(clamp(ux, -lim, lim));
            e.cmd_pitch = 16'(clamp(uy, -lim, lim));
            e.err_yaw   = 16'(ex);
            e.err_pitch = 16'(ey);
            if (e.saturated) n_sat++;
            cmd_q.push_back(e);
        endfunction

        function void check_cmd(tvc_pkg::t_cmd got);
            tvc_pkg::t_cmd e;
            n_cmds++;
            if (cmd_q.size() == 0) begin
                $display("%0t: unexpected command beat %h", $time, got);
                errors++;
                return;
            end
            e = cmd_q.pop_front();
            if (got.cmd_yaw !== e.cmd_yaw) begin
                $display("%0t: cmd_yaw exp %0d got %0d", $time, e.cmd_yaw, got.cmd_yaw);
                errors++;
            end
            if (got.cmd_pitch !== e.cmd_pitch) begin
                $display("%0t: cmd_pitch exp %0d got %0d", $time, e.cmd_pitch,
                         got.cmd_pitch);
                errors++;
            end
            if (got.err_yaw !== e.err_yaw) begin
                $display("%0t: err_yaw exp %0d got %0d", $time, e.err_yaw, got.err_yaw);
                errors++;
            end
            if (got.err_pitch !== e.err_pitch) begin
                $display("%0t: err_pitch exp %0d got %0d", $time, e.err_pitch,
                         got.err_pitch);
                errors++;
            end
            if (got.saturated !== e.saturated) begin
                $display("%0t: saturated exp %0b got %0b", $time, e.saturated,
                         got.saturated);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   idle_on;
    int   quiet_cyc;

    tvc_tick_if tick_if ();
    tvc_cmd_if  cmd_if ();
    tvc_cfg_if  cfg_if ();

    cmd_scoreboard sb = new();

    tvc_pd_attitude_control u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick_if),
        .o_cmd   (cmd_if),
        .i_cfg   (cfg_if)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // result side: check each beat, random backpressure
    always @(posedge i_clk) begin
        if (i_rst_n && cmd_if.valid && cmd_if.ready) sb.check_cmd(cmd_if.payload);
        cmd_if.ready <= !(idle_on && $urandom_range(99) < 26);
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((tick_if.valid && tick_if.ready) || (cmd_if.valid && cmd_if.ready) ||
            (cfg_if.valid && cfg_if.ready) || !i_rst_n) begin
            quiet_cyc <= 0;
        end else if (quiet_cyc >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cyc <= quiet_cyc + 1;
        end
    end

    task automatic send_tick(input tvc_pkg::t_tick t);
        while (idle_on && $urandom_range(99) < 26) begin
            tick_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        tick_if.valid   <= 1'b1;
        tick_if.payload <= t;
        do @(posedge i_clk); while (!tick_if.ready);
        sb.note_tick(t);
    endtask

    // drain results, then keep the tick input idle before returning
    task automatic settle();
        tick_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_reg(idx, val);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic tvc_pkg::t_tick mk_tick(logic signed [15:0] w,
                                               logic signed [15:0] x,
                                               logic signed [15:0] y,
                                               logic signed [15:0] z,
                                               logic signed [15:0] rx,
                                               logic signed [15:0] ry,
                                               logic [15:0] dt);
        tvc_pkg::t_tick t;
        t.quat_w  = w;  t.quat_x = x;  t.quat_y = y;  t.quat_z = z;
        t.rate_x  = rx; t.rate_y = ry; t.tick_dt = dt;
        return t;
    endfunction

    // mostly near-level attitudes, some arbitrary (non-unit) quaternions
    function automatic tvc_pkg::t_tick rand_tick();
        tvc_pkg::t_tick t;
        int             sel;
        t   = tvc_pkg::t_tick'(112'({$urandom, $urandom, $urandom, $urandom}));
        sel = $urandom_range(99);
        if (sel < 40) begin
            t.quat_w = 16'(32767 - $urandom_range(2000));
            t.quat_x = 16'($urandom_range(4000) - 2000);
            t.quat_y = 16'($urandom_range(4000) - 2000);
            t.quat_z = 16'($urandom_range(20000) - 10000);
        end else if (sel < 55) begin
            t.quat_w = 16'(32767 - $urandom_range(3));
            t.quat_x = 16'($urandom_range(6) - 3);
            t.quat_y = 16'($urandom_range(6) - 3);
        end
        if ($urandom_range(99) < 50) begin
            t.rate_x = 16'($urandom_range(2000) - 1000);
            t.rate_y = 16'($urandom_range(2000) - 1000);
        end
        if ($urandom_range(99) < 10) t.tick_dt = '0;
        else if (t.tick_dt == 0) t.tick_dt = 16'd1000;
        return t;
    endfunction

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++) begin
            idle_on = !(i >= n / 3 && i < n / 3 + 60);
            send_tick(rand_tick());
        end
        idle_on = 1'b1;
    endtask

    initial begin
        idle_on         = 1'b1;
        i_rst_n         = 1'b0;
        tick_if.valid   = 1'b0;
        tick_if.payload = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = tvc_pkg::CFG_PROP_GAIN;
        cfg_if.data     = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: level, tiny tilt, tilts, flipped, extremes, dropped tick
        send_tick(mk_tick(32767, 0, 0, 0, 0, 0, 1));
        send_tick(mk_tick(32767, 0, 0, 0, 32767, -32768, 65535));
        send_tick(mk_tick(32767, 1, 0, 0, 0, 0, 1));
        send_tick(mk_tick(32767, 0, -1, 0, 100, -100, 1));
        send_tick(mk_tick(23170, 23170, 0, 0, 0, 0, 20000));
        send_tick(mk_tick(23170, 0, 23170, 0, -500, 500, 20000));
        send_tick(mk_tick(0, 32767, 0, 0, 0, 0, 1));
        send_tick(mk_tick(0, 0, 0, 32767, 0, 0, 1));
        send_tick(mk_tick(-32768, -32768, -32768, -32768, -32768, -32768, 65535));
        send_tick(mk_tick(32767, 32767, 32767, 32767, 32767, 32767, 65535));
        send_tick(mk_tick(32767, -32768, 32767, -32768, 0, 0, 1));
        send_tick(mk_tick(0, 0, 0, 0, 0, 0, 1));
        send_tick(mk_tick(30000, 12000, -9000, 3000, 2000, -2000, 0));
        send_tick(mk_tick(30000, 12000, -9000, 3000, 2000, -2000, 5000));
        send_tick(mk_tick(32767, 0, 0, 32767, 0, 0, 1));

        // sender holds off until every command is back
        settle();
        run_random(N_RANDOM / 3);

        // extremes of the gains and limit, plus an ignored index
        settle();
        write_reg(tvc_pkg::CFG_PROP_GAIN, 16'hFFFF);
        write_reg(tvc_pkg::CFG_DERIV_GAIN, 16'hFFFF);
        write_reg(tvc_pkg::CFG_GIMBAL_LIMIT, 16'h7FFF);
        write_reg(CFG_NO_REG, 16'h1234);
        run_random(N_RANDOM / 6);

        settle();
        write_reg(tvc_pkg::CFG_PROP_GAIN, 16'h0000);
        write_reg(tvc_pkg::CFG_DERIV_GAIN, 16'h0000);
        write_reg(tvc_pkg::CFG_GIMBAL_LIMIT, 16'h8000);
        run_random(N_RANDOM / 6);

        settle();
        write_reg(tvc_pkg::CFG_PROP_GAIN, 16'($urandom_range(2048)));
        write_reg(tvc_pkg::CFG_DERIV_GAIN, 16'($urandom_range(512)));
        write_reg(tvc_pkg::CFG_GIMBAL_LIMIT, 16'(1 + $urandom_range(32766)));
        run_random(N_RANDOM / 3);

        settle();
        if (sb.pending() > 0) begin
            $display("%0t: %0d commands never arrived", $time, sb.pending());
            sb.errors++;
        end
        $display("Checked %0d command beats (%0d saturated, %0d near-level axis cases)",
                 sb.n_cmds, sb.n_sat, sb.n_tiny);
        $display("over default, extreme, zero and random gain and limit settings");
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
